// ===== rtl/sdss_pkg.sv =====
// Shared types and constants for the stick direction sector select block.
// No dependencies.
package sdss_pkg;

  localparam int AXIS_W = 16;
  localparam int SLOT_W = 7;
  localparam int DZ_W = 15;
  localparam int WGT_W = 16;
  localparam int IDX_W = 6;
  localparam int SWID_W = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int TABLE_LEN = 24;
  localparam int MAX_SLOTS = 64;

  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_WEIGHT = 2'd2;

  typedef struct packed {
    logic signed [AXIS_W-1:0] x;
    logic signed [AXIS_W-1:0] y;
  } sample_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0: v = 32'h20000000;
      5'd1: v = 32'h12E4051E;
      5'd2: v = 32'h09FB385B;
      5'd3: v = 32'h051111D4;
      5'd4: v = 32'h028B0D43;
      5'd5: v = 32'h0145D7E1;
      5'd6: v = 32'h00A2F61E;
      5'd7: v = 32'h00517C55;
      5'd8: v = 32'h0028BE53;
      5'd9: v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/sdss_front.sv =====
// Front end: registers each sample, tests it against the dead zone and pushes passing samples to the queue.
// Depends on sdss_pkg.
module sdss_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  sdss_pkg::sample_t        in_smp,
  input  logic [sdss_pkg::DZ_W-1:0] dead_zone,
  output logic                     push,
  output sdss_pkg::sample_t        push_smp,
  input  logic                     q_full
);
  import sdss_pkg::*;

  logic              busy_r;
  sample_t           smp_r;
  logic [32:0]       mag2_c;
  logic [29:0]       dz2_r;
  logic signed [31:0] xx, yy;

  assign xx = 32'(smp_r.x) * 32'(smp_r.x);
  assign yy = 32'(smp_r.y) * 32'(smp_r.y);
  assign in_ready = !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      busy_r <= 1'b1;
    end else if (busy_r && !q_full) begin
      busy_r <= 1'b0;
    end
    if (in_valid && in_ready) begin
      smp_r <= in_smp;
      dz2_r <= 30'(dead_zone) * 30'(dead_zone);
    end
  end

  assign mag2_c = {1'b0, xx} + {1'b0, yy};
  assign push = busy_r && !q_full && (mag2_c >= {3'b0, dz2_r});
  assign push_smp = smp_r;
endmodule

// ===== rtl/sdss_queue.sv =====
// Two-entry sample queue between front and back end.
// Depends on sdss_pkg.
module sdss_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sdss_pkg::sample_t push_smp,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output sdss_pkg::sample_t pop_smp
);
  import sdss_pkg::*;

  sample_t    mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign pop_smp = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) mem_r[wp_r] <= push_smp;
  end
endmodule

// ===== rtl/sdss_back.sv =====
// Back end: smoothing, integer sqrt, restoring divides, CORDIC and sector math.
// Depends on sdss_pkg.
module sdss_back #(
  parameter int ANGLE_BITS = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  output logic                         q_pop,
  input  sdss_pkg::sample_t            q_smp,
  input  logic [sdss_pkg::SLOT_W-1:0]  slot_count,
  input  logic [sdss_pkg::WGT_W-1:0]   smooth_weight,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sdss_pkg::IDX_W-1:0]   out_index,
  output logic [sdss_pkg::SWID_W-1:0]  out_width
);
  import sdss_pkg::*;

  localparam int NS = (MAX_SLOTS > 127) ? 9 : 7;
  localparam int AW = 40;
  localparam int PW = ANGLE_BITS + NS + 1;

  localparam logic [3:0] S_IDLE = 4'd0, S_BX = 4'd1, S_BY = 4'd2, S_SQ = 4'd3,
    S_MAG = 4'd4, S_SQRT = 4'd5, S_DIV = 4'd6, S_CINIT = 4'd7, S_CORD = 4'd8,
    S_SEC = 4'd9, S_WID = 4'd10, S_OUT = 4'd11;

  logic [3:0]  st_r;
  sample_t     in_r;
  logic signed [15:0] sx_r, sy_r;
  logic [31:0] prod_r;
  logic [31:0] mag_r, rem_r, root_r;
  logic [4:0]  cnt_r;
  logic        comp_r;
  logic [31:0] num_r;
  logic [16:0] quo_r;
  logic signed [AW-1:0] cx_r, cy_r;
  logic [31:0] acc_r;
  logic [NS-1:0] n_r;
  logic [IDX_W-1:0] idx_r;
  logic [SWID_W-1:0] wid_r;
  logic [16:0] wrem_r;

  logic signed [17:0] wgt_c, inv_c;
  logic signed [33:0] bl_c;
  logic signed [17:0] bl_sh_c;
  logic [31:0] sqx_c, sqy_c;
  logic [33:0] t_c;
  logic [32:0] rb_c;
  logic [16:0] mag_abs;
  logic signed [AW-1:0] dx_c, dy_c;
  logic [31:0] tab_c, round_c;
  logic [ANGLE_BITS-1:0] ang_c, a_c;
  logic [PW-1:0] prodn_c;
  logic [NS:0] idxr_c;
  logic [NS-1:0] ncl_c;
  logic [17:0] wsub_c;

  assign wgt_c = {2'b0, smooth_weight};
  assign inv_c = 18'sd65536 - wgt_c;

  always_comb begin
    if (st_r == S_BX) bl_c = 34'(sx_r) * 34'(inv_c) + 34'(signed'(in_r.x)) * 34'(wgt_c);
    else bl_c = 34'(sy_r) * 34'(inv_c) + 34'(signed'(in_r.y)) * 34'(wgt_c);
    bl_sh_c = 18'((bl_c + 34'sd32768) >>> 16);
  end

  assign sqx_c = 32'(sx_r) * 32'(sx_r);
  assign sqy_c = 32'(sy_r) * 32'(sy_r);

  assign mag_abs = comp_r ? (sy_r[15] ? -(17'(sy_r)) : {1'b0, sy_r})
                          : (sx_r[15] ? -(17'(sx_r)) : {1'b0, sx_r});
  assign rb_c = {1'b0, root_r} + (33'd1 << {cnt_r, 1'b0});
  assign t_c = {2'b0, rem_r} - {1'b0, rb_c};
  assign dx_c = cy_r >>> cnt_r;
  assign dy_c = cx_r >>> cnt_r;
  assign tab_c = atan_turn(cnt_r);
  assign round_c = acc_r + (32'd1 << (31 - ANGLE_BITS));
  assign ang_c = round_c[31 -: ANGLE_BITS];
  assign a_c = ang_c + ANGLE_BITS'(1 << (ANGLE_BITS - 2));
  assign prodn_c = PW'(a_c) * PW'(n_r) + (PW'(1) << (ANGLE_BITS - 1));
  assign idxr_c = prodn_c[ANGLE_BITS +: NS+1];
  assign ncl_c = (slot_count == '0) ? NS'(1) :
                 ({{(NS>SLOT_W?NS-SLOT_W:1){1'b0}}, slot_count} > MAX_SLOTS) ?
                 NS'(MAX_SLOTS) : NS'(slot_count);
  assign wsub_c = {wrem_r, cnt_r == 5'd16} - {{(18-NS){1'b0}}, n_r};

  assign q_pop = (st_r == S_IDLE) && q_valid;
  assign out_valid = st_r == S_OUT;
  assign out_index = idx_r;
  assign out_width = wid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      sx_r <= '0;
      sy_r <= '0;
    end else begin
      unique case (st_r)
        S_IDLE: if (q_valid) begin
          in_r <= q_smp;
          n_r <= ncl_c;
          st_r <= S_BX;
        end
        S_BX: begin
          sx_r <= (bl_sh_c > 18'sd32767) ? 16'sd32767 : bl_sh_c[15:0];
          st_r <= S_BY;
        end
        S_BY: begin
          sy_r <= (bl_sh_c > 18'sd32767) ? 16'sd32767 : bl_sh_c[15:0];
          comp_r <= 1'b0;
          st_r <= S_SQ;
        end
        S_SQ: begin
          prod_r <= sqx_c;
          mag_r <= sqy_c;
          st_r <= S_MAG;
        end
        S_MAG: begin
          rem_r <= prod_r + mag_r;
          root_r <= '0;
          cnt_r <= 5'd15;
          st_r <= S_SQRT;
        end
        S_SQRT: begin
          if (!t_c[33]) begin
            rem_r <= t_c[31:0];
            root_r <= (root_r >> 1) + (32'd1 << {cnt_r, 1'b0});
          end else begin
            root_r <= root_r >> 1;
          end
          if (cnt_r == 5'd0) begin
            st_r <= S_DIV;
            comp_r <= 1'b0;
            cnt_r <= 5'd0;
            num_r <= '0;
            quo_r <= '0;
          end else cnt_r <= cnt_r - 5'd1;
        end
        S_DIV: begin
          if (root_r == '0) begin
            sx_r <= '0;
            sy_r <= '0;
            acc_r <= '0;
            st_r <= S_SEC;
          end else begin
            // long division of mag<<15 by root, one quotient bit per cycle
            if (cnt_r == 5'd0) begin
              num_r <= {15'b0, mag_abs} >> 16;
              quo_r <= '0;
              cnt_r <= 5'd1;
            end else begin
              logic [31:0] nn;
              logic [32:0] nd;
              nn = {num_r[30:0], (cnt_r <= 5'd16) ? mag_abs[5'd16 - cnt_r] : 1'b0};
              nd = {1'b0, nn} - {1'b0, root_r};
              if (!nd[32]) begin
                num_r <= nd[31:0];
                quo_r <= {quo_r[15:0], 1'b1};
              end else begin
                num_r <= nn;
                quo_r <= {quo_r[15:0], 1'b0};
              end
              if (cnt_r == 5'd31) begin
                cnt_r <= 5'd0;
                comp_r <= !comp_r;
                if (!comp_r) begin
                  sx_r <= sx_r[15] ? -{quo_r[14:0], !nd[32]}
                        : (({quo_r[15:0], !nd[32]} > 17'd32767) ? 16'sd32767
                        : 16'({quo_r[15:0], !nd[32]}));
                end else begin
                  sy_r <= sy_r[15] ? -{quo_r[14:0], !nd[32]}
                        : (({quo_r[15:0], !nd[32]} > 17'd32767) ? 16'sd32767
                        : 16'({quo_r[15:0], !nd[32]}));
                  st_r <= S_CINIT;
                end
              end else cnt_r <= cnt_r + 5'd1;
            end
          end
        end
        S_CINIT: begin
          if (sx_r[15]) begin
            cx_r <= -(AW'(sx_r) <<< 16);
            cy_r <= -(AW'(sy_r) <<< 16);
            acc_r <= 32'h80000000;
          end else begin
            cx_r <= AW'(sx_r) <<< 16;
            cy_r <= AW'(sy_r) <<< 16;
            acc_r <= '0;
          end
          cnt_r <= '0;
          st_r <= S_CORD;
        end
        S_CORD: begin
          if (cy_r > 0) begin
            cx_r <= cx_r + dx_c;
            cy_r <= cy_r - dy_c;
            acc_r <= acc_r + tab_c;
          end else begin
            cx_r <= cx_r - dx_c;
            cy_r <= cy_r + dy_c;
            acc_r <= acc_r - tab_c;
          end
          if ({27'b0, cnt_r} == CORDIC_STEPS - 1 || cnt_r == 5'(TABLE_LEN - 1))
            st_r <= S_SEC;
          cnt_r <= cnt_r + 5'd1;
        end
        S_SEC: begin
          idx_r <= IDX_W'((idxr_c >= {1'b0, n_r}) ? idxr_c - {1'b0, n_r} : idxr_c);
          wrem_r <= '0;
          wid_r <= '0;
          cnt_r <= 5'd16;
          st_r <= S_WID;
        end
        S_WID: begin
          // 65536 / n, one quotient bit per cycle
          if (!wsub_c[17]) begin
            wrem_r <= wsub_c[16:0];
            wid_r <= {wid_r[15:0], 1'b1};
          end else begin
            wrem_r <= {wrem_r[15:0], cnt_r == 5'd16};
            wid_r <= {wid_r[15:0], 1'b0};
          end
          if (cnt_r == 5'd0) st_r <= S_OUT;
          else cnt_r <= cnt_r - 5'd1;
        end
        S_OUT: if (out_ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/stick_direction_sector_select_core.sv =====
// Top level of the stick direction sector select block: config registers,
// front end, sample queue and back end. Depends on sdss_pkg and the sdss_* modules.
//
//  channel | dir | handshake           | data
//  in_     | in  | in_tvalid/in_tready | in_tdata  = axis_x, axis_y
//  out_    | out | out_tvalid/tready   | out_tdata = sector_index, sector_width
//  cfg_    | in  | cfg_we              | cfg_index, cfg_data
//
// In the back end an item passes through 16 square root steps, two restoring
// divides, the CORDIC loop and a 17-step sector width divide, with setup and
// handoff states between; the divides and the CORDIC loop are skipped when the
// smoothed direction is zero. The front end takes no new sample while it holds one,
// and holds it while the two-entry queue is full, stalling in_tready.
// Reset is synchronous, active low, and restores register defaults.
module stick_direction_sector_select_core #(
  parameter int ANGLE_BITS = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // axis_x[15:0], axis_y[31:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // sector_index[5:0], sector_width[22:6], zero pad
  input  logic        cfg_we,
  input  logic [sdss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sdss_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sdss_pkg::*;

  logic [SLOT_W-1:0] slot_r;
  logic [DZ_W-1:0]   dz_r;
  logic [WGT_W-1:0]  wgt_r;
  sample_t in_smp, push_smp, pop_smp;
  logic push, full, pop, not_empty;
  logic [IDX_W-1:0] idx;
  logic [SWID_W-1:0] wid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= 7'd8;
      dz_r <= 15'd6554;
      wgt_r <= 16'd6554;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SLOT_COUNT: slot_r <= cfg_data[SLOT_W-1:0];
        REG_DEAD_ZONE: dz_r <= cfg_data[DZ_W-1:0];
        REG_SMOOTH_WEIGHT: wgt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_smp.x = in_tdata[15:0];
  assign in_smp.y = in_tdata[31:16];
  assign out_tdata = {1'b0, wid, idx};

  sdss_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_smp,
    .dead_zone(dz_r), .push, .push_smp, .q_full(full)
  );

  sdss_queue u_queue (
    .clk, .rst_n, .push, .push_smp, .full, .pop, .not_empty, .pop_smp
  );

  sdss_back #(
    .ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)
  ) u_back (
    .clk, .rst_n, .q_valid(not_empty), .q_pop(pop), .q_smp(pop_smp),
    .slot_count(slot_r), .smooth_weight(wgt_r), .out_valid(out_tvalid),
    .out_ready(out_tready), .out_index(idx), .out_width(wid)
  );
endmodule
